@@ hw/rtl/backslash_escape_decoder_macros.svh @@
// Assertion macros shared by the decoder RTL.
`ifndef BACKSLASH_ESCAPE_DECODER_MACROS_SVH
`define BACKSLASH_ESCAPE_DECODER_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge outside of reset.
`define BED_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
// The consequent must hold in the clock cycle after the antecedent.
`define BED_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BED_ASSERT(lbl, clk, rstn, prop)
`define BED_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/bed_pkg.sv @@
`default_nettype none
package bed_pkg;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_OCT   = 2'd2,
        MODE_HEX   = 2'd3
    } mode_t;

    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_N    = 8'h6E;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_7    = 8'h37;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_TAB  = 8'h09;

    // Digit count at which a run is complete, minus one.
    localparam logic [1:0] OCT_LAST_IDX = 2'd2;
    localparam logic [1:0] HEX_LAST_IDX = 2'd1;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t r;
        r.ok  = 1'b1;
        r.val = 4'd0;
        if (b >= CH_0 && b <= CH_9) begin
            r.val = b[3:0];
        end else if ((b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF)) begin
            r.val = 4'(b[2:0] + 3'd1) + 4'd8;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/backslash_escape_decoder.sv @@
// Backslash escape decoder, one text byte per input beat.
// Latency: a result is offered on m_ the cycle after its input beat is taken.
// Throughput: one input beat per cycle while m_tready is high; a beat that yields
// two result beats holds s_tready low while the two-entry result buffer drains.
// Reset: aresetn is synchronous, active low; it empties the result buffer and
// returns the decoder to plain text mode with a cleared digit run.
`default_nettype none
module backslash_escape_decoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // in_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast    // out_last
);
    import bed_pkg::*;
    `include "backslash_escape_decoder_macros.svh"

    mode_t      mode_reg, mode_next;
    logic [1:0] dcnt_reg, dcnt_next;
    logic [7:0] acc_reg, acc_next;

    // Result buffer: up to two beats from one input beat.
    logic [1:0] cnt_reg, cnt_next;
    logic [7:0] q0_byte_reg, q0_byte_next, q1_byte_reg, q1_byte_next;
    logic       q0_last_reg, q0_last_next, q1_last_reg, q1_last_next;

    logic       push, pop;
    logic [7:0] res [2];
    logic [1:0] nres;
    logic       do_plain;
    hex_digit_t hd;

    assign s_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = q0_byte_reg;
    assign m_tlast  = q0_last_reg;
    assign push     = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign hd       = hex_decode(s_tdata);

    always_comb begin
        mode_next = mode_reg;
        dcnt_next = dcnt_reg;
        acc_next  = acc_reg;
        res[0]    = 8'h00;
        res[1]    = 8'h00;
        nres      = 2'd0;
        do_plain  = 1'b0;

        unique case (mode_reg)
            MODE_PLAIN: begin
                do_plain = 1'b1;
            end
            MODE_ESC: begin
                mode_next = MODE_PLAIN;
                unique case (s_tdata)
                    CH_BSL: begin
                        res[0] = CH_BSL;
                        nres   = 2'd1;
                    end
                    CH_N: begin
                        res[0] = CH_NL;
                        nres   = 2'd1;
                    end
                    CH_R: begin
                        res[0] = CH_CR;
                        nres   = 2'd1;
                    end
                    CH_T: begin
                        res[0] = CH_TAB;
                        nres   = 2'd1;
                    end
                    CH_0: begin
                        mode_next = MODE_OCT;
                        dcnt_next = 2'd0;
                        acc_next  = 8'h00;
                    end
                    CH_X: begin
                        mode_next = MODE_HEX;
                        dcnt_next = 2'd0;
                        acc_next  = 8'h00;
                    end
                    default: begin
                        res[0] = CH_BSL;
                        res[1] = s_tdata;
                        nres   = 2'd2;
                    end
                endcase
            end
            MODE_OCT: begin
                if (s_tdata >= CH_0 && s_tdata <= CH_7) begin
                    acc_next  = {acc_reg[4:0], s_tdata[2:0]};
                    dcnt_next = dcnt_reg + 2'd1;
                    if (dcnt_reg == OCT_LAST_IDX) begin
                        mode_next = MODE_PLAIN;
                        res[0]    = acc_next;
                        nres      = 2'd1;
                    end
                end else begin
                    res[0]   = acc_reg;
                    nres     = 2'd1;
                    do_plain = 1'b1;
                end
            end
            MODE_HEX: begin
                if (hd.ok) begin
                    acc_next  = {acc_reg[3:0], hd.val};
                    dcnt_next = dcnt_reg + 2'd1;
                    if (dcnt_reg == HEX_LAST_IDX) begin
                        mode_next = MODE_PLAIN;
                        res[0]    = acc_next;
                        nres      = 2'd1;
                    end
                end else begin
                    // An empty hex run stands for a plain x.
                    res[0]   = (dcnt_reg != 2'd0) ? acc_reg : CH_X;
                    nres     = 2'd1;
                    do_plain = 1'b1;
                end
            end
            default: begin
                mode_next = MODE_PLAIN;
            end
        endcase

        if (do_plain) begin
            if (s_tdata == CH_BSL && !s_tlast) begin
                mode_next = MODE_ESC;
            end else begin
                mode_next    = MODE_PLAIN;
                res[nres[0]] = s_tdata;
                nres         = nres + 2'd1;
            end
        end

        // On the last byte a pending run or escape is flushed.
        if (s_tlast) begin
            if (mode_next == MODE_OCT) begin
                res[nres[0]] = acc_next;
                nres         = nres + 2'd1;
            end else if (mode_next == MODE_HEX) begin
                res[nres[0]] = (dcnt_next != 2'd0) ? acc_next : CH_X;
                nres         = nres + 2'd1;
            end else if (mode_next == MODE_ESC) begin
                res[nres[0]] = CH_BSL;
                nres         = nres + 2'd1;
            end
            mode_next = MODE_PLAIN;
            dcnt_next = 2'd0;
            acc_next  = 8'h00;
        end
    end

    always_comb begin
        cnt_next     = cnt_reg;
        q0_byte_next = q0_byte_reg;
        q0_last_next = q0_last_reg;
        q1_byte_next = q1_byte_reg;
        q1_last_next = q1_last_reg;
        if (push) begin
            // s_tready guarantees the buffer is empty once this cycle's pop is done.
            cnt_next     = nres;
            q0_byte_next = res[0];
            q0_last_next = s_tlast && (nres == 2'd1);
            q1_byte_next = res[1];
            q1_last_next = s_tlast;
        end else if (pop) begin
            cnt_next     = cnt_reg - 2'd1;
            q0_byte_next = q1_byte_reg;
            q0_last_next = q1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PLAIN;
            dcnt_reg <= 2'd0;
            acc_reg  <= 8'h00;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) begin
                mode_reg <= mode_next;
                dcnt_reg <= dcnt_next;
                acc_reg  <= acc_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_byte_reg <= q0_byte_next;
        q0_last_reg <= q0_last_next;
        q1_byte_reg <= q1_byte_next;
        q1_last_reg <= q1_last_next;
    end

    `BED_ASSERT(a_cnt_range, aclk, aresetn, cnt_reg != 2'd3)
    `BED_ASSERT_NEXT(a_last_gives_result, aclk, aresetn, push && s_tlast, cnt_reg != 2'd0)
    `BED_ASSERT_NEXT(a_last_clears_state, aclk, aresetn, push && s_tlast,
                     mode_reg == MODE_PLAIN && dcnt_reg == 2'd0 && acc_reg == 8'h00)
    `BED_ASSERT(a_last_on_final, aclk, aresetn, !(cnt_reg == 2'd2 && q0_last_reg))

endmodule
`default_nettype wire
